// File: rtl/core/eau_pkg.sv
// Package for the x86 effective address unit: encoding constants, the
// decode control struct passed between stages. No dependencies.
`timescale 1ns / 1ps

package eau_pkg;

  localparam int unsigned RegCount = 8;
  localparam int unsigned RegIdxW  = 3;
  localparam int unsigned WordW    = 32;

  localparam logic KIND_WRITE  = 1'b0;
  localparam logic KIND_DECODE = 1'b1;

  localparam logic [1:0] MOD_NODISP = 2'b00;
  localparam logic [1:0] MOD_DISP8  = 2'b01;
  localparam logic [1:0] MOD_DISPW  = 2'b10;
  localparam logic [1:0] MOD_REG    = 2'b11;

  localparam logic [2:0] RM_SIB      = 3'b100;
  localparam logic [2:0] RM_DISP32   = 3'b101;
  localparam logic [2:0] RM_DISP16   = 3'b110;
  localparam logic [2:0] IDX_NONE    = 3'b100;
  localparam logic [2:0] BASE_NOBASE = 3'b101;

  localparam logic [2:0] RM16_BX_SI = 3'b000;
  localparam logic [2:0] RM16_BX_DI = 3'b001;
  localparam logic [2:0] RM16_BP_SI = 3'b010;
  localparam logic [2:0] RM16_BP_DI = 3'b011;
  localparam logic [2:0] RM16_SI    = 3'b100;
  localparam logic [2:0] RM16_DI    = 3'b101;
  localparam logic [2:0] RM16_BP    = 3'b110;
  localparam logic [2:0] RM16_BX    = 3'b111;

  localparam logic [2:0] REG_BX = 3'd3;
  localparam logic [2:0] REG_BP = 3'd5;
  localparam logic [2:0] REG_SI = 3'd6;
  localparam logic [2:0] REG_DI = 3'd7;

  typedef struct packed {
    logic             use_base;
    logic             use_index;
    logic [1:0]       scale;
    logic [WordW-1:0] disp;
    logic             wrap16;
    logic             is_register;
    logic [2:0]       direct_register;
    logic [2:0]       bytes_used;
    logic             uses_sib;
  } eau_ctrl_t;

endpackage

// File: rtl/core/eau_item_if.sv
// Input channel of the effective address unit: valid/ready handshake and
// the item payload. Uses no package.
`timescale 1ns / 1ps

interface eau_item_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [2:0]  reg_number;
  logic [31:0] reg_value;
  logic [7:0]  modrm;
  logic [7:0]  sib;
  logic [31:0] displacement;
  logic        address_size_32;

  modport source (
    output valid, kind, reg_number, reg_value, modrm, sib, displacement,
           address_size_32,
    input  ready
  );

  modport sink (
    input  valid, kind, reg_number, reg_value, modrm, sib, displacement,
           address_size_32,
    output ready
  );
endinterface

// File: rtl/core/eau_result_if.sv
// Output channel of the effective address unit: valid/ready handshake and
// the result payload. Uses no package.
`timescale 1ns / 1ps

interface eau_result_if;
  logic        valid;
  logic        ready;
  logic [31:0] address;
  logic        is_register;
  logic [2:0]  direct_register;
  logic [2:0]  bytes_used;
  logic        uses_sib;

  modport source (
    output valid, address, is_register, direct_register, bytes_used, uses_sib,
    input  ready
  );

  modport sink (
    input  valid, address, is_register, direct_register, bytes_used, uses_sib,
    output ready
  );
endinterface

// File: rtl/core/eau_regfile.sv
// Eight-entry general register memory with one write port and two
// registered read ports. Uses eau_pkg for sizes.
`timescale 1ns / 1ps

module eau_regfile (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             write_en,
  input  logic [eau_pkg::RegIdxW-1:0]      write_addr,
  input  logic [eau_pkg::WordW-1:0]        write_data,
  input  logic                             read_en,
  input  logic [eau_pkg::RegIdxW-1:0]      base_addr,
  input  logic [eau_pkg::RegIdxW-1:0]      index_addr,
  output logic [eau_pkg::WordW-1:0]        base_value,
  output logic [eau_pkg::WordW-1:0]        index_value
);

  logic [eau_pkg::WordW-1:0]    mem [eau_pkg::RegCount];
  logic [eau_pkg::RegCount-1:0] written;
  logic [eau_pkg::WordW-1:0]    base_data;
  logic [eau_pkg::WordW-1:0]    index_data;
  logic                         base_written;
  logic                         index_written;

  // An entry never written since reset reads as zero.
  always_ff @(posedge clk) begin
    if (rst) begin
      written <= '0;
    end else if (write_en) begin
      written[write_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (write_en) begin
      mem[write_addr] <= write_data;
    end
  end

  always_ff @(posedge clk) begin
    if (read_en) begin
      base_data     <= mem[base_addr];
      index_data    <= mem[index_addr];
      base_written  <= written[base_addr];
      index_written <= written[index_addr];
    end
  end

  assign base_value  = base_written  ? base_data  : '0;
  assign index_value = index_written ? index_data : '0;

endmodule

// File: rtl/core/eau_decode.sv
// ModRM/SIB decoder: picks the registers to read and builds the control
// word for the address stage. Uses eau_pkg.
`timescale 1ns / 1ps

module eau_decode (
  input  logic [7:0]                   modrm,
  input  logic [7:0]                   sib,
  input  logic [31:0]                  displacement,
  input  logic                         address_size_32,
  output logic [eau_pkg::RegIdxW-1:0]  base_addr,
  output logic [eau_pkg::RegIdxW-1:0]  index_addr,
  output eau_pkg::eau_ctrl_t           ctrl
);

  logic [1:0]  mod_f;
  logic [2:0]  rm;
  logic [2:0]  sib_index;
  logic [2:0]  sib_base;
  logic [31:0] disp8;
  logic [31:0] disp16;

  assign mod_f     = modrm[7:6];
  assign rm        = modrm[2:0];
  assign sib_index = sib[5:3];
  assign sib_base  = sib[2:0];
  assign disp8     = {{24{displacement[7]}}, displacement[7:0]};
  assign disp16    = {{16{displacement[15]}}, displacement[15:0]};

  always_comb begin
    base_addr                  = rm;
    index_addr                 = sib_index;
    ctrl.use_base              = 1'b0;
    ctrl.use_index             = 1'b0;
    ctrl.scale                 = 2'b00;
    ctrl.disp                  = '0;
    ctrl.wrap16                = ~address_size_32;
    ctrl.is_register           = 1'b0;
    ctrl.direct_register       = 3'd0;
    ctrl.bytes_used            = 3'd0;
    ctrl.uses_sib              = 1'b0;

    if (mod_f == eau_pkg::MOD_REG) begin
      ctrl.is_register     = 1'b1;
      ctrl.direct_register = rm;
      ctrl.wrap16          = 1'b0;
    end else if (!address_size_32) begin
      ctrl.use_base = 1'b1;
      unique case (rm)
        eau_pkg::RM16_BX_SI: begin
          base_addr = eau_pkg::REG_BX; index_addr = eau_pkg::REG_SI; ctrl.use_index = 1'b1;
        end
        eau_pkg::RM16_BX_DI: begin
          base_addr = eau_pkg::REG_BX; index_addr = eau_pkg::REG_DI; ctrl.use_index = 1'b1;
        end
        eau_pkg::RM16_BP_SI: begin
          base_addr = eau_pkg::REG_BP; index_addr = eau_pkg::REG_SI; ctrl.use_index = 1'b1;
        end
        eau_pkg::RM16_BP_DI: begin
          base_addr = eau_pkg::REG_BP; index_addr = eau_pkg::REG_DI; ctrl.use_index = 1'b1;
        end
        eau_pkg::RM16_SI: base_addr = eau_pkg::REG_SI;
        eau_pkg::RM16_DI: base_addr = eau_pkg::REG_DI;
        eau_pkg::RM16_BP: base_addr = eau_pkg::REG_BP;
        default:          base_addr = eau_pkg::REG_BX;
      endcase
      unique case (mod_f)
        eau_pkg::MOD_NODISP: begin
          if (rm == eau_pkg::RM_DISP16) begin
            ctrl.use_base   = 1'b0;
            ctrl.disp       = disp16;
            ctrl.bytes_used = 3'd2;
          end
        end
        eau_pkg::MOD_DISP8: begin
          ctrl.disp       = disp8;
          ctrl.bytes_used = 3'd1;
        end
        default: begin
          ctrl.disp       = disp16;
          ctrl.bytes_used = 3'd2;
        end
      endcase
    end else if (rm == eau_pkg::RM_SIB) begin
      base_addr      = sib_base;
      ctrl.uses_sib  = 1'b1;
      ctrl.scale     = sib[7:6];
      ctrl.use_index = (sib_index != eau_pkg::IDX_NONE);
      ctrl.use_base  = 1'b1;
      unique case (mod_f)
        eau_pkg::MOD_NODISP: begin
          if (sib_base == eau_pkg::BASE_NOBASE) begin
            ctrl.use_base   = 1'b0;
            ctrl.disp       = displacement;
            ctrl.bytes_used = 3'd5;
          end else begin
            ctrl.bytes_used = 3'd1;
          end
        end
        eau_pkg::MOD_DISP8: begin
          ctrl.disp       = disp8;
          ctrl.bytes_used = 3'd2;
        end
        default: begin
          ctrl.disp       = displacement;
          ctrl.bytes_used = 3'd5;
        end
      endcase
    end else begin
      ctrl.use_base = 1'b1;
      unique case (mod_f)
        eau_pkg::MOD_NODISP: begin
          if (rm == eau_pkg::RM_DISP32) begin
            ctrl.use_base   = 1'b0;
            ctrl.disp       = displacement;
            ctrl.bytes_used = 3'd4;
          end
        end
        eau_pkg::MOD_DISP8: begin
          ctrl.disp       = disp8;
          ctrl.bytes_used = 3'd1;
        end
        default: begin
          ctrl.disp       = displacement;
          ctrl.bytes_used = 3'd4;
        end
      endcase
    end
  end

endmodule

// File: rtl/core/eau_agen.sv
// Address stage: adds base, scaled index and displacement and holds the
// result in the output register. Uses eau_pkg and eau_result_if.
`timescale 1ns / 1ps

module eau_agen (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      stage_valid,
  input  eau_pkg::eau_ctrl_t        ctrl,
  input  logic [eau_pkg::WordW-1:0] base_value,
  input  logic [eau_pkg::WordW-1:0] index_value,
  output logic                      take,
  eau_result_if.source              result
);

  logic [eau_pkg::WordW-1:0] base_term;
  logic [eau_pkg::WordW-1:0] index_term;
  logic [eau_pkg::WordW-1:0] sum;
  logic [eau_pkg::WordW-1:0] address_next;

  assign base_term    = ctrl.use_base ? base_value : '0;
  assign index_term   = ctrl.use_index ? (index_value << ctrl.scale) : '0;
  assign sum          = base_term + index_term + ctrl.disp;
  assign address_next = ctrl.wrap16 ? {16'h0000, sum[15:0]} : sum;

  // The stage may move forward whenever the output register is empty or
  // its transfer completes in this cycle.
  assign take = !result.valid || result.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (take) begin
      result.valid <= stage_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take && stage_valid) begin
      result.address         <= address_next;
      result.is_register     <= ctrl.is_register;
      result.direct_register <= ctrl.direct_register;
      result.bytes_used      <= ctrl.bytes_used;
      result.uses_sib        <= ctrl.uses_sib;
    end
  end

endmodule

// File: rtl/core/x86_effective_address_unit.sv
// Top level of the x86 effective address unit. Depends on eau_pkg,
// eau_item_if, eau_result_if, eau_regfile, eau_decode and eau_agen.
`timescale 1ns / 1ps

// The unit takes one item every cycle while its input is not held off. A
// write item updates the register memory at its transfer and is seen by
// the very next decode item. A decode item reads its base and index
// registers from the two read ports of the register memory at its
// transfer, the sum is formed in the next cycle and loaded into the output
// register once that register is free. While a finished result waits on
// the output, the unit still takes write items and at most one more
// decode item, and then holds off its input until the output transfer.
// Throughput is set by the single write/two-read register memory, which
// serves one item per cycle unless the input is held off.
module x86_effective_address_unit (
  input  logic         clk,
  input  logic         rst,
  eau_item_if.sink     item,
  eau_result_if.source result
);

  logic                          item_transfer;
  logic                          decode_transfer;
  logic                          take;
  logic                          stage_valid;
  logic [eau_pkg::RegIdxW-1:0]   base_addr;
  logic [eau_pkg::RegIdxW-1:0]   index_addr;
  logic [eau_pkg::WordW-1:0]     base_value;
  logic [eau_pkg::WordW-1:0]     index_value;
  eau_pkg::eau_ctrl_t            ctrl_next;
  eau_pkg::eau_ctrl_t            ctrl;

  assign item.ready      = !stage_valid || take;
  assign item_transfer   = item.valid && item.ready;
  assign decode_transfer = item_transfer && (item.kind == eau_pkg::KIND_DECODE);

  eau_decode u_decode (
    .modrm           (item.modrm),
    .sib             (item.sib),
    .displacement    (item.displacement),
    .address_size_32 (item.address_size_32),
    .base_addr       (base_addr),
    .index_addr      (index_addr),
    .ctrl            (ctrl_next)
  );

  eau_regfile u_regfile (
    .clk         (clk),
    .rst         (rst),
    .write_en    (item_transfer && (item.kind == eau_pkg::KIND_WRITE)),
    .write_addr  (item.reg_number),
    .write_data  (item.reg_value),
    .read_en     (decode_transfer),
    .base_addr   (base_addr),
    .index_addr  (index_addr),
    .base_value  (base_value),
    .index_value (index_value)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (decode_transfer) begin
      stage_valid <= 1'b1;
    end else if (take) begin
      stage_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (decode_transfer) begin
      ctrl <= ctrl_next;
    end
  end

  eau_agen u_agen (
    .clk         (clk),
    .rst         (rst),
    .stage_valid (stage_valid),
    .ctrl        (ctrl),
    .base_value  (base_value),
    .index_value (index_value),
    .take        (take),
    .result      (result)
  );

endmodule
